>>> hdl/rfi_pkg.sv
`default_nettype none
package rfi_pkg;

  localparam int STEP_COUNT_BITS = 8;
  localparam int CHAN_W          = 9;
  localparam int FADE_W          = 8;
  localparam int BYTE_W          = 8;
  localparam int NUM_CHAN        = 3;
  localparam int CHAN_IDX_W      = $clog2(NUM_CHAN);
  localparam int DIV_ITER        = CHAN_W;
  localparam int CNT_W           = $clog2(DIV_ITER);
  localparam int SAT_W           = (STEP_COUNT_BITS > FADE_W) ? STEP_COUNT_BITS : FADE_W;

  localparam logic [CHAN_W-1:0]          NEUTRAL   = CHAN_W'(9'h100);
  localparam logic [STEP_COUNT_BITS-1:0] STEP_MAX  = '1;
  localparam logic [CHAN_IDX_W-1:0]      LAST_CHAN = CHAN_IDX_W'(NUM_CHAN - 1);
  localparam logic [CNT_W-1:0]           LAST_ITER = CNT_W'(DIV_ITER - 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_WB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CHAN_W-1:0] target_red;
    logic [CHAN_W-1:0] target_green;
    logic [CHAN_W-1:0] target_blue;
    logic [FADE_W-1:0] fade_steps;
  } in_word_t;

  typedef struct packed {
    logic              draw_overlay;
    logic [BYTE_W-1:0] tile_red;
    logic [BYTE_W-1:0] tile_green;
    logic [BYTE_W-1:0] tile_blue;
    logic              subtractive_blend;
  } out_word_t;

  typedef struct packed {
    logic                  accept;
    logic                  div_load;
    logic                  div_step;
    logic                  div_wb;
    logic                  emit;
    logic [CHAN_IDX_W-1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/rfi_ctrl.sv
`default_nettype none
module rfi_ctrl import rfi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  input  wire status_t    status,
  output logic            in_stall,
  output cmd_t            cmd
);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CHAN_IDX_W-1:0] chan_r, chan_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chan_r  <= chan_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    chan_nxt  = chan_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.chan  = chan_r;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_op == OP_TICK) begin
          chan_nxt = '0;
          // no steps left: snap happens on accept, go straight to the overlay
          state_nxt = status.steps_zero ? ST_EMIT : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST_ITER) begin
          state_nxt = ST_WB;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_WB: begin
        cmd.div_wb = 1'b1;
        if (chan_r == LAST_CHAN) begin
          state_nxt = ST_EMIT;
        end else begin
          chan_nxt  = chan_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/rfi_dpath.sv
`default_nettype none
module rfi_dpath import rfi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_word_t in_data,
  input  wire cmd_t     cmd,
  input  wire logic     out_stall,
  output status_t       status,
  output logic          out_valid,
  output out_word_t     out_data
);

  logic [CHAN_W-1:0]          cur_r  [NUM_CHAN];
  logic [CHAN_W-1:0]          goal_r [NUM_CHAN];
  logic [STEP_COUNT_BITS-1:0] steps_r;

  logic [CHAN_W-1:0]          dvd_r;
  logic [STEP_COUNT_BITS:0]   rem_r;
  logic                       neg_r;

  logic                       out_valid_r;
  out_word_t                  out_data_r;

  logic [CHAN_W-1:0]          cur_sel, goal_sel;
  logic [CHAN_W:0]            diff;
  logic [CHAN_W:0]            diff_mag;
  logic [STEP_COUNT_BITS:0]   rem_sh;
  logic                       q_bit;
  logic [SAT_W-1:0]           steps_ext;
  logic [STEP_COUNT_BITS-1:0] steps_sat;
  logic                       out_free;
  out_word_t                  overlay;

  function automatic logic [BYTE_W-1:0] sub_byte(input logic [CHAN_W-1:0] v);
    logic [BYTE_W-1:0] b;
    b = (v == NEUTRAL) ? '0 : ~v[BYTE_W-1:0];
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] add_byte(input logic [CHAN_W-1:0] v);
    logic [CHAN_W-1:0] m;
    m = v - 1'b1;
    return m[BYTE_W-1:0];
  endfunction

  assign cur_sel  = cur_r[cmd.chan];
  assign goal_sel = goal_r[cmd.chan];
  assign diff     = {1'b0, goal_sel} - {1'b0, cur_sel};
  assign diff_mag = diff[CHAN_W] ? -diff : diff;

  assign rem_sh = {rem_r[STEP_COUNT_BITS-1:0], dvd_r[CHAN_W-1]};
  assign q_bit  = rem_sh >= {1'b0, steps_r};

  assign steps_ext = SAT_W'(in_data.fade_steps);
  assign steps_sat = (steps_ext > SAT_W'(STEP_MAX)) ? STEP_MAX
                                                    : steps_ext[STEP_COUNT_BITS-1:0];

  assign out_free          = !out_valid_r || !out_stall;
  assign status.out_free   = out_free;
  assign status.steps_zero = (steps_r == '0);

  always_comb begin
    overlay = '0;
    if (!(cur_r[0] == NEUTRAL && cur_r[1] == NEUTRAL && cur_r[2] == NEUTRAL)) begin
      overlay.draw_overlay = 1'b1;
      if (cur_r[0] > NEUTRAL) begin
        overlay.tile_red   = add_byte(cur_r[0]);
        overlay.tile_green = add_byte(cur_r[1]);
        overlay.tile_blue  = add_byte(cur_r[2]);
      end else begin
        overlay.tile_red          = sub_byte(cur_r[0]);
        overlay.tile_green        = sub_byte(cur_r[1]);
        overlay.tile_blue         = sub_byte(cur_r[2]);
        overlay.subtractive_blend = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        cur_r[i]  <= '0;
        goal_r[i] <= '0;
      end
      steps_r <= '0;
    end else if (cmd.accept) begin
      case (in_data.opcode)
        OP_CLEAR: begin
          for (int i = 0; i < NUM_CHAN; i++) begin
            cur_r[i]  <= '0;
            goal_r[i] <= '0;
          end
          steps_r <= '0;
        end
        OP_SET: begin
          goal_r[0] <= in_data.target_red;
          goal_r[1] <= in_data.target_green;
          goal_r[2] <= in_data.target_blue;
          steps_r   <= steps_sat;
        end
        OP_TICK: begin
          if (steps_r == '0) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
              cur_r[i] <= goal_r[i];
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.div_wb) begin
      // quotient already truncated toward zero: apply it with the sign of the gap
      cur_r[cmd.chan] <= neg_r ? cur_sel - dvd_r : cur_sel + dvd_r;
      if (cmd.chan == LAST_CHAN) begin
        steps_r <= steps_r - 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle, quotient shifts into dvd_r
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r <= diff_mag[CHAN_W-1:0];
      neg_r <= diff[CHAN_W];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[CHAN_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sh - {1'b0, steps_r} : rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      out_data_r <= overlay;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> hdl/rgb_fade_interpolator.sv
// Channel | Dir | Ports                          | Word
// input   | in  | in_valid, in_stall, in_data    | in_word_t (opcode, target, fade_steps)
// output  | out | out_valid, out_stall, out_data | out_word_t (overlay flag, bytes, blend)
//
// Clear and set target complete on accept; a tick with no steps left goes straight to emit.
// A stepping tick runs three channels through one serial divider, each with a load,
// a 9-bit quotient and a write-back, then emits the overlay.
// Reset (rst_n low, synchronous) zeroes colors, goal and step count.
// The output register frees the input while a result waits; a tick stalls
// at emit only while the previous result is still held.
`default_nettype none
module rgb_fade_interpolator import rfi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_data
);

  cmd_t    cmd;
  status_t status;

  rfi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.opcode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rfi_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_TICK |=> in_stall)
    else $error("tick accepted without going busy");

  a_cfg_op_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode != OP_TICK |=> !in_stall)
    else $error("non-tick word left block busy");

  a_no_overlay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.draw_overlay |->
      out_data.tile_red == '0 && out_data.tile_green == '0 &&
      out_data.tile_blue == '0 && !out_data.subtractive_blend)
    else $error("hidden overlay carries nonzero fields");

endmodule
`default_nettype wire

>>> tb/rgb_fade_interpolator_tb.sv
module rgb_fade_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfi_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         MAX_SHOWN   = 10;
  localparam int         DRAIN_WAIT  = 80;
  localparam int         HOLD_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  rgb_fade_interpolator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // fade state as the block should hold it; index 0 red, 1 green, 2 blue
  logic [CHAN_W-1:0]          level_now  [NUM_CHAN] = '{default: '0};
  logic [CHAN_W-1:0]          level_goal [NUM_CHAN] = '{default: '0};
  logic [STEP_COUNT_BITS-1:0] steps_left = '0;

  out_word_t overlay_q[$];
  int        errors = 0;
  int        fade_words = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_left = 0;

  task automatic flag_error(input string msg);
    if (errors < MAX_SHOWN) $display("[%0t] %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [BYTE_W-1:0] tile_byte(input logic [CHAN_W-1:0] lvl,
                                                  input logic sub);
    logic [CHAN_W-1:0] less_one;
    if (sub) return (lvl == NEUTRAL) ? '0 : ~lvl[BYTE_W-1:0];
    less_one = lvl - 1'b1;
    return less_one[BYTE_W-1:0];
  endfunction

  // update the fade state for one accepted word and queue the overlay it yields
  task automatic fade_predict(input in_word_t w);
    out_word_t ov;
    int        diff;
    int        nv;
    logic      sub;
    case (w.opcode)
      OP_CLEAR: begin
        level_now  = '{default: '0};
        level_goal = '{default: '0};
        steps_left = '0;
      end
      OP_SET: begin
        level_goal[0] = w.target_red;
        level_goal[1] = w.target_green;
        level_goal[2] = w.target_blue;
        if (SAT_W'(w.fade_steps) > SAT_W'(STEP_MAX)) steps_left = STEP_MAX;
        else steps_left = STEP_COUNT_BITS'(w.fade_steps);
      end
      OP_TICK: begin
        if (steps_left != 0) begin
          for (int c = 0; c < NUM_CHAN; c++) begin
            diff = int'(level_goal[c]) - int'(level_now[c]);
            nv = int'(level_now[c]) + diff / int'(steps_left);
            level_now[c] = nv[CHAN_W-1:0];
          end
          steps_left = steps_left - 1'b1;
        end else begin
          level_now = level_goal;
        end
        ov = '0;
        if (!(level_now[0] == NEUTRAL && level_now[1] == NEUTRAL &&
              level_now[2] == NEUTRAL)) begin
          sub = !(level_now[0] > NEUTRAL);
          ov.draw_overlay      = 1'b1;
          ov.tile_red          = tile_byte(level_now[0], sub);
          ov.tile_green        = tile_byte(level_now[1], sub);
          ov.tile_blue         = tile_byte(level_now[2], sub);
          ov.subtractive_blend = sub;
        end
        overlay_q.push_back(ov);
      end
      default: ;
    endcase
  endtask

  // offer one word after a random idle gap; hold it until taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    fade_predict(w);
    if (w.opcode != OP_UNUSED) fade_words++;
  endtask

  function automatic in_word_t junk_word(input logic [1:0] op);
    logic [63:0] r;
    in_word_t    w;
    r = {$urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    w.opcode = op;
    return w;
  endfunction

  task automatic set_target(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic [FADE_W-1:0] s);
    in_word_t w;
    w = junk_word(OP_SET);
    w.target_red   = r;
    w.target_green = g;
    w.target_blue  = b;
    w.fade_steps   = s;
    send_word(w);
  endtask

  task automatic frame_ticks(input int n);
    repeat (n) send_word(junk_word(OP_TICK));
  endtask

  function automatic logic [CHAN_W-1:0] pick_level();
    case ($urandom_range(9))
      0, 1:    return NEUTRAL;
      2:       return $urandom_range(1) ? NEUTRAL + 1'b1 : NEUTRAL - 1'b1;
      3:       return '0;
      4:       return '1;
      default: return CHAN_W'($urandom_range(511));
    endcase
  endfunction

  function automatic logic [FADE_W-1:0] pick_steps();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return FADE_W'($urandom_range(255));
      default: return FADE_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  task automatic test_snap_after_reset();
    frame_ticks(1);
  endtask

  task automatic test_all_neutral();
    set_target(NEUTRAL, NEUTRAL, NEUTRAL, 8'd0);
    frame_ticks(1);
  endtask

  task automatic test_additive_blend();
    set_target(9'd511, 9'd0, NEUTRAL, 8'd0);
    frame_ticks(1);
  endtask

  task automatic test_subtractive_blend();
    set_target(NEUTRAL, 9'd0, 9'd511, 8'd0);
    frame_ticks(1);
  endtask

  task automatic test_long_fade();
    set_target(9'd0, 9'd511, NEUTRAL + 1'b1, 8'd255);
    frame_ticks(2);
  endtask

  task automatic test_short_fade();
    set_target(NEUTRAL + 1'b1, NEUTRAL, NEUTRAL - 1'b1, 8'd3);
    frame_ticks(4);
  endtask

  task automatic test_unused_opcode();
    in_word_t w;
    w = '1;
    w.opcode = OP_UNUSED;
    send_word(w);
    frame_ticks(1);
  endtask

  task automatic test_clear();
    send_word(junk_word(OP_CLEAR));
    frame_ticks(1);
  endtask

  // mostly whole fades with random content, some stray and broken words
  task automatic test_random_fades(input int count);
    int start;
    int ticks;
    start = fade_words;
    while (fade_words - start < count) begin
      case ($urandom_range(19))
        0: send_word(junk_word(OP_CLEAR));
        1: send_word(junk_word(OP_UNUSED));
        2: frame_ticks(1);
        3: begin
          set_target(NEUTRAL, NEUTRAL, NEUTRAL, pick_steps());
          frame_ticks(int'(steps_left) + 1);
        end
        default: begin
          set_target(pick_level(), pick_level(), pick_level(), pick_steps());
          ticks = (steps_left > 10) ? 10 : int'(steps_left);
          frame_ticks(ticks + $urandom_range(2));
        end
      endcase
    end
  endtask

  // receiver holds off while the sender keeps offering ticks
  task automatic test_backpressure();
    set_idling(0, 0);
    set_target(CHAN_W'($urandom_range(511)), pick_level(), pick_level(), 8'd40);
    hold_left = HOLD_CYCLES;
    frame_ticks(30);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_overlay
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (overlay_q.size() == 0) begin
        flag_error($sformatf("unexpected result word %h", out_data));
      end else begin
        want = overlay_q.pop_front();
        if (out_data.draw_overlay !== want.draw_overlay ||
            out_data.tile_red !== want.tile_red ||
            out_data.tile_green !== want.tile_green ||
            out_data.tile_blue !== want.tile_blue ||
            out_data.subtractive_blend !== want.subtractive_blend)
          flag_error($sformatf(
            "overlay mismatch: draw %b/%b red %h/%h green %h/%h blue %h/%h sub %b/%b (exp/act)",
            want.draw_overlay, out_data.draw_overlay, want.tile_red, out_data.tile_red,
            want.tile_green, out_data.tile_green, want.tile_blue, out_data.tile_blue,
            want.subtractive_blend, out_data.subtractive_blend));
      end
    end
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_snap_after_reset();
    test_all_neutral();
    test_additive_blend();
    test_subtractive_blend();
    test_long_fade();
    test_short_fade();
    test_unused_opcode();
    test_clear();

    set_idling(0, 0);
    test_random_fades(375);
    set_idling(54, 0);
    test_random_fades(375);
    set_idling(0, 54);
    test_random_fades(375);
    set_idling(6, 6);
    test_random_fades(375);

    test_backpressure();
    in_valid <= 1'b0;

    while (overlay_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (overlay_q.size() != 0)
      flag_error($sformatf("%0d overlay words never arrived", overlay_q.size()));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rfi_pkg.sv
hdl/rfi_ctrl.sv
hdl/rfi_dpath.sv
hdl/rgb_fade_interpolator.sv
tb/rgb_fade_interpolator_tb.sv
